FILE: src/rcd_pkg.sv
// Shared types and constants for the RTCP compound deframer.
package rcd_pkg;

  localparam int unsigned MaxBufferBytes = 65536;
  localparam int unsigned OutFifoDepth   = 4;

  localparam logic [1:0] RtcpVersion = 2'd2;

  localparam logic [7:0] PtSr   = 8'd200;
  localparam logic [7:0] PtRr   = 8'd201;
  localparam logic [7:0] PtSdes = 8'd202;
  localparam logic [7:0] PtBye  = 8'd203;
  localparam logic [7:0] PtXr   = 8'd207;

  typedef enum logic [2:0] {
    KIND_SR   = 3'd0,
    KIND_RR   = 3'd1,
    KIND_SDES = 3'd2,
    KIND_BYE  = 3'd3,
    KIND_XR   = 3'd4,
    KIND_END  = 3'd5,
    KIND_SKIP = 3'd7
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] pkt_offset;
    logic [18:0] pkt_length;
    logic        error_seen;
    logic        too_short;
    logic        last;
  } out_t;

endpackage

FILE: src/rtcp_compound_deframer.sv
// Splits a compound RTCP byte stream into sub-packet reports and an end record.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+----------------------------
//  in      | in  | in_valid_i / in_stall_o | in_data_i  (data, final)
//  out     | out | out_valid_o/ out_stall_i| out_data_o (one report)
//
// One byte is taken per cycle unless stalled; its header capture and counter
// update finish in the cycle it is taken, and its reports enter a 4-entry
// result queue. A byte gives at most two reports (packet and end record), so a
// sustained rate of one byte per cycle holds while the output drains one per
// cycle. in_stall_o rises when the queue has fewer than two free entries.
// Reset is asynchronous, active low; it empties the queue and clears parsing
// control state. The final byte of a buffer returns that state to reset.
module rtcp_compound_deframer #(
  parameter int unsigned MAX_BUFFER_BYTES = rcd_pkg::MaxBufferBytes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rcd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rcd_pkg::out_t out_data_o
);
  import rcd_pkg::*;

  localparam int unsigned PosW  = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int unsigned PtrW  = $clog2(OutFifoDepth);
  localparam int unsigned CntW  = $clog2(OutFifoDepth + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_BUFFER_BYTES);

  // parsing state
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     start_q, start_d;
  logic [17:0]     left_q, left_d;
  logic [1:0]      hcnt_q, hcnt_d;
  logic [23:0]     hdr_q, hdr_d;
  logic [18:0]     len_q, len_d;
  kind_e           kind_q, kind_d;
  logic            err_q, err_d;
  logic            stopped_q, stopped_d;

  // result queue
  out_t            fifo_mem [OutFifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  logic            in_acc, out_acc;
  logic [31:0]     full_hdr;
  logic [16:0]     pos_ext;
  logic            finished;
  logic            emit_pkt;
  logic            short_rep;
  logic            tiny;
  out_t            pkt_rec, end_rec;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  assign full_hdr = {hdr_q, in_data_i.data_byte};
  assign pos_ext  = 17'(pos_q);
  assign tiny     = pos_q < PosW'(3);

  always_comb begin
    pos_d     = (pos_q < MaxPos) ? pos_q + PosW'(1) : pos_q;
    start_d   = start_q;
    left_d    = left_q;
    hcnt_d    = hcnt_q;
    hdr_d     = hdr_q;
    len_d     = len_q;
    kind_d    = kind_q;
    err_d     = err_q;
    stopped_d = stopped_q;
    finished  = 1'b0;
    emit_pkt  = 1'b0;
    short_rep = 1'b0;

    // stop on a buffer that runs past the size limit
    if (!stopped_q && pos_q >= MaxPos) begin
      err_d     = 1'b1;
      stopped_d = 1'b1;
    end

    if (!stopped_d) begin
      if (left_q == '0) begin
        hdr_d = {hdr_q[15:0], in_data_i.data_byte};
        if (hcnt_q == 2'd3) begin
          hcnt_d = 2'd0;
          if (full_hdr[31:30] != RtcpVersion) begin
            err_d     = 1'b1;
            stopped_d = 1'b1;
          end else begin
            len_d  = {1'b0, full_hdr[15:0], 2'b00} + 19'd4;
            left_d = {full_hdr[15:0], 2'b00};
            kind_d = KIND_SKIP;
            case (full_hdr[23:16])
              PtSr: begin
                short_rep = len_d < 19'd28 + 19'(full_hdr[28:24]) * 19'd24;
                kind_d    = short_rep ? KIND_SKIP : KIND_SR;
              end
              PtRr: begin
                short_rep = len_d < 19'd8 + 19'(full_hdr[28:24]) * 19'd24;
                kind_d    = short_rep ? KIND_SKIP : KIND_RR;
              end
              PtSdes:  kind_d = KIND_SDES;
              PtBye:   kind_d = KIND_BYE;
              PtXr:    kind_d = KIND_XR;
              default: kind_d = KIND_SKIP;
            endcase
            if (short_rep) begin
              err_d = 1'b1;
            end
            finished = (full_hdr[15:0] == 16'd0);
          end
        end else begin
          hcnt_d = hcnt_q + 2'd1;
        end
      end else begin
        left_d   = left_q - 18'd1;
        finished = (left_q == 18'd1);
      end
    end

    pkt_rec.kind       = kind_d;
    pkt_rec.pkt_offset = start_q;
    pkt_rec.pkt_length = len_d;
    pkt_rec.error_seen = err_d;
    pkt_rec.too_short  = 1'b0;
    pkt_rec.last       = 1'b0;

    if (finished) begin
      emit_pkt = (kind_d != KIND_SKIP);
      start_d  = 16'(pos_ext + 17'd1);
      kind_d   = KIND_SKIP;
      hcnt_d   = 2'd0;
    end

    // a header or packet cut off by the buffer end is an overrun
    if (in_data_i.final_byte && !tiny && !stopped_d && !finished) begin
      err_d = 1'b1;
    end

    end_rec.kind       = KIND_END;
    end_rec.pkt_offset = 16'd0;
    end_rec.pkt_length = 19'd0;
    end_rec.error_seen = tiny ? 1'b0 : err_d;
    end_rec.too_short  = tiny;
    end_rec.last       = 1'b1;

    if (in_data_i.final_byte) begin
      pos_d     = '0;
      start_d   = 16'd0;
      left_d    = 18'd0;
      hcnt_d    = 2'd0;
      kind_d    = KIND_SKIP;
      err_d     = 1'b0;
      stopped_d = 1'b0;
    end
  end

  // parsing control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      start_q   <= 16'd0;
      left_q    <= 18'd0;
      hcnt_q    <= 2'd0;
      kind_q    <= KIND_SKIP;
      err_q     <= 1'b0;
      stopped_q <= 1'b0;
    end else if (in_acc) begin
      pos_q     <= pos_d;
      start_q   <= start_d;
      left_q    <= left_d;
      hcnt_q    <= hcnt_d;
      kind_q    <= kind_d;
      err_q     <= err_d;
      stopped_q <= stopped_d;
    end
  end

  // header bytes and length hold no control meaning until captured
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hdr_q <= hdr_d;
      len_q <= len_d;
    end
  end

  logic            push_a, push_b;
  out_t            rec_a;
  logic [CntW-1:0] n_push;

  assign push_a = in_acc && (emit_pkt || in_data_i.final_byte);
  assign push_b = in_acc && emit_pkt && in_data_i.final_byte;
  assign rec_a  = emit_pkt ? pkt_rec : end_rec;
  assign n_push = CntW'(push_a) + CntW'(push_b);

  always_ff @(posedge clk_i) begin
    if (push_a) begin
      fifo_mem[wr_q] <= rec_a;
    end
    if (push_b) begin
      fifo_mem[wr_q + PtrW'(1)] <= end_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(n_push);
      rd_q  <= rd_q + PtrW'(out_acc);
      cnt_q <= cnt_q + n_push - CntW'(out_acc);
    end
  end

  // hold input while fewer than two entries are free
  assign in_stall_o  = cnt_q > CntW'(OutFifoDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = fifo_mem[rd_q];

`ifndef NO_ASSERTIONS
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(OutFifoDepth))
    else $error("result queue over capacity");

  a_room_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> cnt_q <= CntW'(OutFifoDepth - 2))
    else $error("byte taken without room for two reports");

  a_stop_sets_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> err_q)
    else $error("parsing stopped without error flag");

  a_final_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.final_byte) |=> (pos_q == '0 && !err_q && !stopped_q
      && left_q == 18'd0 && hcnt_q == 2'd0))
    else $error("parsing state not cleared after final byte");
`endif

endmodule
